// ===== design/sandpile_synchronous_stencil_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sandpile stencil assertion macros
// Shared property shorthands for the checker of the sandpile stencil core.
// ----------------------------------------------------------------------------
`ifndef SANDPILE_SYNCHRONOUS_STENCIL_CORE_DEFINES_SVH
`define SANDPILE_SYNCHRONOUS_STENCIL_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// Sandpile stencil package
// Widths, defaults and shared types of the sandpile stencil core.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int GRAIN_W        = 32;
    localparam int SIDE_W         = 11;
    localparam int MAX_SIDE_DEF   = 1024;
    localparam int COUNT_BITS_DEF = 32;
    localparam int MIN_SIDE       = 3;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd1024;

    // per-cell tags that travel with a word down the pipe
    typedef struct packed {
        logic emit;   // interior cell one row and one column back is done
        logic last;   // final interior cell of the sweep
        logic clear;  // cell (0,0): restart the sweep change flag
    } cell_tag_t;

endpackage

// ===== design/sandpile_synchronous_stencil_core.sv =====
// A result word is registered out of the line RAM read stage and the quarter-sum stage.
// Throughput: one cell per cycle; the window row of cells shifts once per
// cell, and each line RAM does one read and one write per cycle.
// Stalls on the result side hold the whole pipe only when a result is due.
// Reset (rst_n low, async) clears positions, window, flags and sets the side
// to 1024; line RAM contents are undefined until written by a sweep.
// ----------------------------------------------------------------------------
// Sandpile synchronous stencil core
// Streaming abelian sandpile step: two line RAMs, a 3x3 chain of window
// cells and a saturating quarter-sum stage.
// ----------------------------------------------------------------------------
module sandpile_synchronous_stencil_core #(
    parameter int MAX_SIDE   = sss_pkg::MAX_SIDE_DEF,
    parameter int COUNT_BITS = sss_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sss_pkg::SIDE_W-1:0]  grid_side,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sss_pkg::GRAIN_W-1:0] grains,
    input  logic                        sweep_start,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sss_pkg::GRAIN_W-1:0] new_grains,
    output logic                        cell_changed,
    output logic                        any_changed,
    output logic                        last_cell,
    output logic                        saturated
);

    import sss_pkg::*;

    localparam int PW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int CW = (SW > SIDE_W) ? SW : SIDE_W;
    localparam int C  = COUNT_BITS;

    // ---------------- configuration ----------------
    logic [SIDE_W-1:0] side_reg;
    logic [CW-1:0]     side_ext;
    logic [SW-1:0]     side;
    logic [SW-1:0]     side_m1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            side_reg <= grid_side;
        end
    end

    always_comb
    begin
        side_ext = CW'(side_reg);
        if (side_ext < CW'(MIN_SIDE))
        begin
            side = SW'(MIN_SIDE);
        end
        else if (side_ext > CW'(MAX_SIDE))
        begin
            side = SW'(MAX_SIDE);
        end
        else
        begin
            side = side_ext[SW-1:0];
        end
        side_m1 = side - SW'(1);
    end

    // ---------------- pipe control ----------------
    logic      enable;
    logic      accept;
    logic      s1_valid_reg;
    logic      s2_valid_reg;
    cell_tag_t s1_tag_reg;
    cell_tag_t s2_tag_reg;

    // advance unless a due result would overrun a waiting one
    assign enable   = !(s2_valid_reg && s2_tag_reg.emit) || !out_valid || out_ready;
    assign in_ready = enable;
    assign accept   = in_valid && in_ready;

    // ---------------- position tracking ----------------
    logic [PW-1:0] row_reg, row_next;
    logic [PW-1:0] col_reg, col_next;
    logic [SW-1:0] r_w, c_w;
    logic [PW-1:0] cur_c;
    logic          border;
    cell_tag_t     cur_tag;
    logic [C-1:0]  cur_v;

    always_comb
    begin
        r_w = sweep_start ? '0 : SW'(row_reg);
        c_w = sweep_start ? '0 : SW'(col_reg);
        // positions past a shrunken side wrap
        if (c_w >= side)
        begin
            c_w = '0;
            r_w = r_w + SW'(1);
        end
        if (r_w >= side)
        begin
            r_w = '0;
        end
        cur_c = c_w[PW-1:0];

        border = (r_w == '0) || (c_w == '0) || (r_w == side_m1) || (c_w == side_m1);
        cur_v  = border ? '0 : C'(grains);

        cur_tag.emit  = (r_w >= SW'(2)) && (c_w >= SW'(2));
        cur_tag.last  = (r_w == side_m1) && (c_w == side_m1);
        cur_tag.clear = (r_w == '0) && (c_w == '0);

        if (c_w == side_m1)
        begin
            col_next = '0;
            row_next = (r_w == side_m1) ? '0 : PW'(r_w + SW'(1));
        end
        else
        begin
            col_next = PW'(c_w + SW'(1));
            row_next = r_w[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ---------------- stage 1: line RAM read, bypass ----------------
    logic [PW-1:0] s1_col_reg;
    logic [C-1:0]  s1_v_reg;
    logic          fwd_hit_reg;
    logic [C-1:0]  fwd_upper_reg;
    logic [C-1:0]  fwd_middle_reg;
    logic [C-1:0]  upper_rd, middle_rd;
    logic [C-1:0]  upper_eff, middle_eff;
    logic          ram_we;

    assign upper_eff  = fwd_hit_reg ? fwd_upper_reg  : upper_rd;
    assign middle_eff = fwd_hit_reg ? fwd_middle_reg : middle_rd;
    assign ram_we     = enable && s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_tag_reg   <= '0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (enable)
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_tag_reg  <= cur_tag;
                // same column written by the word ahead in this very cycle
                fwd_hit_reg <= s1_valid_reg && (cur_c == s1_col_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg     <= cur_c;
            s1_v_reg       <= cur_v;
            fwd_upper_reg  <= middle_eff;
            fwd_middle_reg <= s1_v_reg;
        end
    end

    sss_ram #(
        .WIDTH (C),
        .DEPTH (MAX_SIDE)
    ) u_ram_upper (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (middle_eff),
        .re    (accept),
        .raddr (cur_c),
        .rdata (upper_rd)
    );

    sss_ram #(
        .WIDTH (C),
        .DEPTH (MAX_SIDE)
    ) u_ram_middle (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (s1_v_reg),
        .re    (accept),
        .raddr (cur_c),
        .rdata (middle_rd)
    );

    // ---------------- window: 3 rows of 3 cells ----------------
    logic [C-1:0] row_in [3];
    logic [C-1:0] win    [9];

    assign row_in[0] = upper_eff;
    assign row_in[1] = middle_eff;
    assign row_in[2] = s1_v_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            logic [C-1:0] d_in;
            if (j == 2)
            begin : g_head
                assign d_in = row_in[k];
            end
            else
            begin : g_body
                assign d_in = win[k*3 + j + 1];
            end
            sss_cell #(
                .WIDTH (C)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (ram_we),
                .d     (d_in),
                .q     (win[k*3 + j])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_tag_reg   <= '0;
        end
        else if (enable)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_tag_reg   <= s1_tag_reg;
        end
    end

    // ---------------- stage 2: quarter sum ----------------
    logic [C:0]   total;
    logic [C-1:0] sum;
    logic         sat;
    logic         changed;
    logic         flag_reg, flag_next;

    always_comb
    begin
        total = (C+1)'(win[4][1:0])
              + (C+1)'(win[1] >> 2) + (C+1)'(win[7] >> 2)
              + (C+1)'(win[3] >> 2) + (C+1)'(win[5] >> 2);
        sat     = total[C];
        sum     = sat ? '1 : total[C-1:0];
        changed = (sum != win[4]);
        flag_next = (s2_tag_reg.clear ? 1'b0 : flag_reg)
                  | (s2_tag_reg.emit && changed);
    end

    logic                 out_valid_reg;
    logic [GRAIN_W-1:0]   grains_reg;
    logic                 changed_reg;
    logic                 any_reg;
    logic                 last_reg;
    logic                 sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (enable && s2_valid_reg)
            begin
                flag_reg <= flag_next;
            end
            if (enable && s2_valid_reg && s2_tag_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable && s2_valid_reg && s2_tag_reg.emit)
        begin
            grains_reg  <= GRAIN_W'(sum);
            changed_reg <= changed;
            any_reg     <= flag_next;
            last_reg    <= s2_tag_reg.last;
            sat_reg     <= sat;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_grains   = grains_reg;
    assign cell_changed = changed_reg;
    assign any_changed  = any_reg;
    assign last_cell    = last_reg;
    assign saturated    = sat_reg;

endmodule

// ===== design/sss_ram.sv =====
// ----------------------------------------------------------------------------
// Sandpile stencil line RAM
// Simple dual-port RAM, one write and one registered read per cycle,
// read returns the old contents on a same-address collision.
// ----------------------------------------------------------------------------
module sss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/sss_cell.sv =====
// ----------------------------------------------------------------------------
// Sandpile stencil window cell
// One count of the 3x3 window; takes its neighbor's word on each shift.
// ----------------------------------------------------------------------------
module sss_cell #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] count_reg;
    logic [WIDTH-1:0] count_next;

    always_comb
    begin
        count_next = shift ? d : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign q = count_reg;

endmodule

// ===== design/sss_checker.sv =====
// ----------------------------------------------------------------------------
// Sandpile stencil port checker
// Watches the core's ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "sandpile_synchronous_stencil_core_defines.svh"

module sss_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [sss_pkg::GRAIN_W-1:0] new_grains,
    input  logic                        cell_changed,
    input  logic                        any_changed,
    input  logic                        saturated
);

    import sss_pkg::*;

    `SSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_grains), "result word dropped or changed while stalled")

    `SSS_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input not ready with empty output")

    `SSS_ASSERT_NOW(a_change_sticky, out_valid && cell_changed, any_changed, "cell changed but sweep flag low")

    `SSS_ASSERT_NOW(a_no_clip, out_valid, !saturated, "quarter sum cannot clip")

endmodule

bind sandpile_synchronous_stencil_core sss_checker u_sss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .new_grains   (new_grains),
    .cell_changed (cell_changed),
    .any_changed  (any_changed),
    .saturated    (saturated)
);

// ===== tb/sv/sandpile_sweep_checker.sv =====
// ----------------------------------------------------------------------------
// Sandpile sweep checker
// Watches the config, cell and result channels of the sandpile stencil core,
// predicts every result word from its own copy of the line buffers and 3x3
// window, and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module sandpile_sweep_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [sss_pkg::SIDE_W-1:0]  grid_side,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [sss_pkg::GRAIN_W-1:0] grains,
    input  logic                        sweep_start,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [sss_pkg::GRAIN_W-1:0] new_grains,
    input  logic                        cell_changed,
    input  logic                        any_changed,
    input  logic                        last_cell,
    input  logic                        saturated,
    output int                          mismatch_count,
    output int                          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import sss_pkg::*;

    localparam longint unsigned COUNT_CEIL = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [GRAIN_W-1:0] count;
        logic               changed;
        logic               sweep_dirty;
        logic               final_cell;
        logic               clipped;
    } cell_result_t;

    logic [SIDE_W-1:0]  side_reg;
    bit [GRAIN_W-1:0]   upper_line [MAX_SIDE_DEF];
    bit [GRAIN_W-1:0]   middle_line [MAX_SIDE_DEF];
    bit [GRAIN_W-1:0]   tap [9];
    int unsigned        row_at;
    int unsigned        col_at;
    bit                 dirty;
    cell_result_t       expected_cells [$];

    initial mismatch_count = 0;
    initial pending_results = 0;

    function automatic int unsigned side_in_use();
        int unsigned s;
        s = side_reg;
        if (s < MIN_SIDE)
            s = MIN_SIDE;
        if (s > MAX_SIDE_DEF)
            s = MAX_SIDE_DEF;
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns  sandpile checker: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic predict_cell(input logic [GRAIN_W-1:0] g, input logic mark);
        int unsigned      s;
        int unsigned      r;
        int unsigned      c;
        bit [GRAIN_W-1:0] v;
        bit [GRAIN_W-1:0] centre;
        bit [GRAIN_W-1:0] quarter [4];
        longint unsigned  total;
        bit               clip;
        cell_result_t     res;
        s = side_in_use();
        v = g;
        if (mark)
        begin
            row_at = 0;
            col_at = 0;
        end
        // side may have shrunk under a running sweep
        if (col_at >= s)
        begin
            col_at = 0;
            row_at++;
        end
        if (row_at >= s)
            row_at = 0;
        r = row_at;
        c = col_at;
        if (r == 0 && c == 0)
            dirty = 1'b0;
        if (r == 0 || c == 0 || r == s - 1 || c == s - 1)
            v = '0;

        for (int k = 0; k < 3; k++)
        begin
            tap[k*3]   = tap[k*3+1];
            tap[k*3+1] = tap[k*3+2];
        end
        tap[2] = upper_line[c];
        tap[5] = middle_line[c];
        tap[8] = v;
        upper_line[c]  = middle_line[c];
        middle_line[c] = v;

        if (r >= 2 && c >= 2)
        begin
            centre = tap[4];
            total = centre[1:0];
            clip = 1'b0;
            quarter[0] = tap[1] >> 2;
            quarter[1] = tap[7] >> 2;
            quarter[2] = tap[3] >> 2;
            quarter[3] = tap[5] >> 2;
            for (int k = 0; k < 4; k++)
            begin
                if (quarter[k] > COUNT_CEIL - total)
                begin
                    total = COUNT_CEIL;
                    clip = 1'b1;
                end
                else
                    total += quarter[k];
            end
            if (total[GRAIN_W-1:0] != centre)
                dirty = 1'b1;
            res.count       = total[GRAIN_W-1:0];
            res.changed     = (total[GRAIN_W-1:0] != centre);
            res.sweep_dirty = dirty;
            res.final_cell  = (r == s - 1 && c == s - 1);
            res.clipped     = clip;
            expected_cells.push_back(res);
        end

        if (c + 1 >= s)
        begin
            col_at = 0;
            row_at = (r + 1 >= s) ? 0 : r + 1;
        end
        else
            col_at = c + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t want;
        if (!rst_n)
        begin
            side_reg = SIDE_RESET;
            row_at = 0;
            col_at = 0;
            dirty = 1'b0;
            foreach (tap[k])
                tap[k] = '0;
            expected_cells.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                side_reg = grid_side;
            if (in_valid && in_ready)
                predict_cell(grains, sweep_start);
            if (out_valid && out_ready)
            begin
                if (expected_cells.size() == 0)
                    report_mismatch($sformatf("unexpected result word, new_grains %h",
                                              new_grains));
                else
                begin
                    want = expected_cells.pop_front();
                    if (new_grains !== want.count)
                        report_mismatch($sformatf("new_grains %h, want %h",
                                                  new_grains, want.count));
                    if (cell_changed !== want.changed)
                        report_mismatch($sformatf("cell_changed %b, want %b",
                                                  cell_changed, want.changed));
                    if (any_changed !== want.sweep_dirty)
                        report_mismatch($sformatf("any_changed %b, want %b",
                                                  any_changed, want.sweep_dirty));
                    if (last_cell !== want.final_cell)
                        report_mismatch($sformatf("last_cell %b, want %b",
                                                  last_cell, want.final_cell));
                    if (saturated !== want.clipped)
                        report_mismatch($sformatf("saturated %b, want %b",
                                                  saturated, want.clipped));
                end
            end
        end
        pending_results = expected_cells.size();
    end

endmodule

// ===== tb/sv/sandpile_synchronous_stencil_core_tb.sv =====
// ----------------------------------------------------------------------------
// Sandpile stencil core testbench
// Streams raster-order grids through the core over a series of grid sides,
// small ones mostly plus partial sweeps at the largest, with random gaps and
// result stalls; the sweep checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module sandpile_synchronous_stencil_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sss_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 6;
    localparam int SMALL_CELLS  = 50;
    localparam int PHASES       = 13;

    typedef enum int {FILL_MAX, FILL_FULL, FILL_SMALL, FILL_STABLE} fill_mode_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [SIDE_W-1:0]  grid_side;
    logic               in_valid;
    logic               in_ready;
    logic [GRAIN_W-1:0] grains;
    logic               sweep_start;
    logic               out_valid;
    logic               out_ready;
    logic [GRAIN_W-1:0] new_grains;
    logic               cell_changed;
    logic               any_changed;
    logic               last_cell;
    logic               saturated;

    int                 mismatch_count;
    int                 pending_results;
    int                 cycle_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_left = 0;

    // stimulus-side view of the raster position
    int unsigned        gen_side;
    int unsigned        gen_row;
    int unsigned        gen_col;
    fill_mode_t         fill;
    int unsigned        side_plan [PHASES] = '{5, 3, 9, 4, 1024, 6, 2047, 16, 0, 7, 12, 1, 8};
    int unsigned        new_side;
    int                 cells;
    bit                 force_mark;

    sandpile_synchronous_stencil_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .grid_side    (grid_side),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .grains       (grains),
        .sweep_start  (sweep_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .new_grains   (new_grains),
        .cell_changed (cell_changed),
        .any_changed  (any_changed),
        .last_cell    (last_cell),
        .saturated    (saturated)
    );

    sandpile_sweep_checker sweep_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .grid_side       (grid_side),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .grains          (grains),
        .sweep_start     (sweep_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .new_grains      (new_grains),
        .cell_changed    (cell_changed),
        .any_changed     (any_changed),
        .last_cell       (last_cell),
        .saturated       (saturated),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned clamp_side(input int unsigned v);
        if (v < MIN_SIDE)
            return MIN_SIDE;
        if (v > MAX_SIDE_DEF)
            return MAX_SIDE_DEF;
        return v;
    endfunction

    function automatic logic [GRAIN_W-1:0] cell_value(input fill_mode_t m);
        case (m)
            FILL_MAX:   return '1;
            FILL_FULL:  return $urandom;
            FILL_SMALL: return $urandom_range(15);
            default:    return $urandom_range(3);
        endcase
    endfunction

    task automatic send_cell(input logic [GRAIN_W-1:0] g, input logic mark);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        grains      <= g;
        sweep_start <= mark;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_side(input logic [SIDE_W-1:0] v);
        cfg_valid <= 1'b1;
        grid_side <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // cells at a border position cause no word, so let the pipe empty out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic next_cell();
        logic mark;
        mark = 1'b0;
        if (gen_col >= gen_side)
        begin
            gen_col = 0;
            gen_row++;
        end
        if (gen_row >= gen_side)
            gen_row = 0;
        if (force_mark)
            mark = 1'b1;
        else if (gen_row == 0 && gen_col == 0)
            mark = ($urandom_range(9) < 7);
        else if ($urandom_range(199) == 0)
            mark = 1'b1;   // abandon the sweep and restart
        force_mark = 1'b0;
        if (mark)
        begin
            gen_row = 0;
            gen_col = 0;
        end
        if (gen_row == 0 && gen_col == 0)
            fill = fill_mode_t'($urandom_range(3));
        send_cell(cell_value(fill), mark);
        if (gen_col + 1 >= gen_side)
        begin
            gen_col = 0;
            gen_row = (gen_row + 1 >= gen_side) ? 0 : gen_row + 1;
        end
        else
            gen_col++;
    endtask

    // receiver: random stalls plus one long hold-off
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sandpile_synchronous_stencil_core_tb: errors");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        grid_side   <= SIDE_RESET;
        in_valid    <= 1'b0;
        grains      <= '0;
        sweep_start <= 1'b0;
        force_mark  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // side below the minimum acts as 3: one interior cell per sweep
        write_side(11'd2);
        for (int k = 0; k < 9; k++)
            send_cell('1, k == 0);
        // wrap into the next sweep with no mark; flag must clear
        for (int k = 0; k < 9; k++)
            send_cell('0, 1'b0);
        gen_side = 3;
        gen_row = 0;
        gen_col = 0;

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 47;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 47;
                end
                default:
                begin
                    send_idle_pct = 35;
                    recv_stall_pct = 35;
                end
            endcase
            write_side(side_plan[p][SIDE_W-1:0]);
            new_side = clamp_side(side_plan[p]);
            // growing reaches line entries the old side never wrote
            force_mark = (new_side > gen_side) || ($urandom_range(1) == 0);
            gen_side = new_side;
            if (gen_side == MAX_SIDE_DEF)
                cells = SMALL_CELLS + $urandom_range(3, 20);
            else
                cells = SMALL_CELLS;
            if (p == 2)
                hold_left = 300;
            for (int k = 0; k < cells; k++)
            begin
                if (p == 5 && k == 30)
                    wait_drained();
                next_cell();
                if (p == 0 && k == 0)
                    fill = FILL_MAX;   // all-ones grid hits the top of the count range
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("sandpile_synchronous_stencil_core_tb: clean");
        else
            $display("sandpile_synchronous_stencil_core_tb: errors");
        $finish;
    end

endmodule
